// File: sv/assert_macros.svh
// Assertion macros used by the checker file mbx_chk.sv.
// Each one takes a label, a disable condition, an antecedent and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MBX_ASSERT_IMP(label, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("mailbox check failed");

// Next-cycle implication.
`define MBX_ASSERT_NXT(label, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("mailbox check failed");

`endif

// File: sv/mbx_pkg.sv
`timescale 1ns / 1ps

package mbx_pkg;

  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_REPLY = 2'd2;

  localparam logic [8:0] OFS_OUT_MSG    = 9'h000;
  localparam logic [8:0] OFS_CTRL       = 9'h004;
  localparam logic [8:0] OFS_IN_MSG     = 9'h008;
  localparam logic [8:0] OFS_OTHER_CTRL = 9'h00C;
  localparam logic [8:0] OFS_RSVD_18    = 9'h018;
  localparam logic [8:0] OFS_RSVD_24    = 9'h024;
  localparam logic [8:0] OFS_ALL_ONES   = 9'h064;
  localparam logic [8:0] OFS_GPIO_OUT_A = 9'h0C0;
  localparam logic [8:0] OFS_GPIO_DIR_A = 9'h0C4;
  localparam logic [8:0] OFS_COVER_A    = 9'h0C8;
  localparam logic [8:0] OFS_GPIO_OUT_B = 9'h0E0;
  localparam logic [8:0] OFS_GPIO_DIR_B = 9'h0E4;
  localparam logic [8:0] OFS_COVER_B    = 9'h0E8;
  localparam logic [8:0] OFS_ZERO_180   = 9'h180;
  localparam logic [8:0] OFS_RESET_WORD = 9'h194;
  localparam logic [8:0] OFS_ZERO_1CC   = 9'h1CC;
  localparam logic [8:0] OFS_ZERO_1D0   = 9'h1D0;

  localparam logic [31:0] SPLIT_MASK = 32'h0000_C3A0;
  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [31:0] COVER_OPEN = 32'h0000_0080;

  typedef struct packed {
    logic ack_ie;
    logic reply_ie;
    logic relaunch;
    logic reply;
    logic ack;
    logic req;
  } ctrl_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [8:0]  reg_offset;
    logic [31:0] write_data;
    logic [31:0] reply_address;
    logic        disc_open;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_request;
    logic        request_pending;
    logic [31:0] outgoing_message;
    logic        unknown_offset;
    logic        reply_dropped;
  } out_item_t;

endpackage

// File: sv/ipc_mailbox_with_reply_queue_top.sv
// Inter-processor mailbox with a queue of replies.
// Input channel (in_valid / in_stall / in_data) carries one event per request:
// a bus read, a bus write, or a reply address arriving from the other side.
// Output channel (out_valid / out_stall / out_data) returns exactly one result
// per request: read data, interrupt level, request flag, outgoing message and
// the unknown-offset and reply-dropped status bits, all after the event.
// Throughput: one request per cycle while in_stall is low; the register update
// and the reply queue head prefetch both finish within the accepting cycle.
// Replies sit in a REPLY_DEPTH-entry memory with a registered read; the head
// entry is prefetched each cycle, with a write to that entry forwarded.
// Output register plus one skid entry: while out_stall is high one further
// request is still taken; in_stall rises only once the skid entry is full.
// Reset (rst_n low, synchronous) clears the mailbox registers, flags and the queue
// pointers and drops any result not yet taken; the queue memory is not cleared.
`timescale 1ns / 1ps

module ipc_mailbox_with_reply_queue_top #(
  parameter int REPLY_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mbx_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mbx_pkg::out_item_t out_data
);

  localparam int PTR_W = (REPLY_DEPTH > 1) ? $clog2(REPLY_DEPTH) : 1;
  localparam int CNT_W = $clog2(REPLY_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [31:0] reply_mem [REPLY_DEPTH];

  logic [31:0]    out_msg_r, out_msg_nxt;
  logic [31:0]    in_msg_r, in_msg_nxt;
  mbx_pkg::ctrl_t ctrl_r, ctrl_nxt, ctrl_w;
  logic [31:0]    gpio_out_r, gpio_out_nxt;
  logic [31:0]    gpio_dir_r, gpio_dir_nxt;
  logic [31:0]    reset_word_r, reset_word_nxt;
  logic [PTR_W-1:0] head_r, head_nxt, head_inc, tail;
  logic [CNT_W-1:0] count_r, count_nxt, count_q;
  logic [SUM_W-1:0] tail_sum;
  logic [31:0]    head_data_r, pdata;

  logic acc, full, enq, pop_req, present;
  mbx_pkg::out_item_t res;

  logic               out_valid_r, skid_valid_r;
  mbx_pkg::out_item_t out_data_r, skid_data_r;

  assign acc  = in_valid && !skid_valid_r;
  assign full = (count_r == CNT_W'(REPLY_DEPTH));

  assign tail_sum = SUM_W'(head_r) + SUM_W'(count_r);
  assign tail     = (tail_sum >= SUM_W'(REPLY_DEPTH)) ?
                    PTR_W'(tail_sum - SUM_W'(REPLY_DEPTH)) : PTR_W'(tail_sum);
  assign head_inc = (head_r == PTR_W'(REPLY_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);

  always_comb begin
    ctrl_w         = ctrl_r;
    out_msg_nxt    = out_msg_r;
    in_msg_nxt     = in_msg_r;
    gpio_out_nxt   = gpio_out_r;
    gpio_dir_nxt   = gpio_dir_r;
    reset_word_nxt = reset_word_r;
    enq            = 1'b0;
    pop_req        = 1'b0;
    res            = '0;
    if (acc) begin
      unique case (in_data.mode)
        mbx_pkg::MODE_READ: begin
          unique case (in_data.reg_offset)
            mbx_pkg::OFS_OUT_MSG:    res.read_data = out_msg_r;
            mbx_pkg::OFS_CTRL:       res.read_data = 32'(ctrl_r);
            mbx_pkg::OFS_IN_MSG:     res.read_data = in_msg_r;
            mbx_pkg::OFS_ALL_ONES:   res.read_data = mbx_pkg::ALL_ONES;
            mbx_pkg::OFS_GPIO_OUT_A,
            mbx_pkg::OFS_GPIO_OUT_B: res.read_data = gpio_out_r;
            mbx_pkg::OFS_GPIO_DIR_A,
            mbx_pkg::OFS_GPIO_DIR_B: res.read_data = gpio_dir_r;
            mbx_pkg::OFS_COVER_A,
            mbx_pkg::OFS_COVER_B:
              res.read_data = in_data.disc_open ? mbx_pkg::COVER_OPEN : '0;
            mbx_pkg::OFS_RESET_WORD: res.read_data = reset_word_r;
            mbx_pkg::OFS_OTHER_CTRL,
            mbx_pkg::OFS_ZERO_180,
            mbx_pkg::OFS_ZERO_1CC,
            mbx_pkg::OFS_ZERO_1D0:   res.read_data = '0;
            default:                 res.unknown_offset = 1'b1;
          endcase
        end
        mbx_pkg::MODE_WRITE: begin
          unique case (in_data.reg_offset)
            mbx_pkg::OFS_OUT_MSG: out_msg_nxt = in_data.write_data;
            mbx_pkg::OFS_CTRL: begin
              ctrl_w.req      = in_data.write_data[0];
              ctrl_w.relaunch = in_data.write_data[3];
              ctrl_w.reply_ie = in_data.write_data[4];
              ctrl_w.ack_ie   = in_data.write_data[5];
              if (in_data.write_data[1]) begin
                ctrl_w.ack = 1'b0;
              end
              if (in_data.write_data[2]) begin
                ctrl_w.reply = 1'b0;
                pop_req      = 1'b1;
              end
            end
            mbx_pkg::OFS_IN_MSG: in_msg_nxt = in_data.write_data;
            mbx_pkg::OFS_GPIO_OUT_A:
              gpio_out_nxt = (gpio_out_r & ~mbx_pkg::SPLIT_MASK)
                           | (in_data.write_data & mbx_pkg::SPLIT_MASK);
            mbx_pkg::OFS_GPIO_DIR_A:
              gpio_dir_nxt = (gpio_dir_r & ~mbx_pkg::SPLIT_MASK)
                           | (in_data.write_data & mbx_pkg::SPLIT_MASK);
            mbx_pkg::OFS_GPIO_OUT_B:
              gpio_out_nxt = (gpio_out_r & mbx_pkg::SPLIT_MASK)
                           | (in_data.write_data & ~mbx_pkg::SPLIT_MASK);
            mbx_pkg::OFS_GPIO_DIR_B:
              gpio_dir_nxt = (gpio_dir_r & mbx_pkg::SPLIT_MASK)
                           | (in_data.write_data & ~mbx_pkg::SPLIT_MASK);
            mbx_pkg::OFS_RESET_WORD: reset_word_nxt = in_data.write_data;
            mbx_pkg::OFS_OTHER_CTRL,
            mbx_pkg::OFS_RSVD_18,
            mbx_pkg::OFS_RSVD_24,
            mbx_pkg::OFS_ALL_ONES,
            mbx_pkg::OFS_COVER_A,
            mbx_pkg::OFS_COVER_B,
            mbx_pkg::OFS_ZERO_180,
            mbx_pkg::OFS_ZERO_1CC,
            mbx_pkg::OFS_ZERO_1D0: ;
            default: res.unknown_offset = 1'b1;
          endcase
        end
        mbx_pkg::MODE_REPLY: begin
          if (full) begin
            res.reply_dropped = 1'b1;
          end else begin
            enq = 1'b1;
          end
          pop_req = 1'b1;
        end
        default: ;
      endcase
    end

    count_q = count_r + CNT_W'(enq);
    present = pop_req && !ctrl_w.reply && (count_q != '0);
    // empty queue: the entry being presented is the one arriving now
    pdata   = (count_r == '0) ? in_data.reply_address : head_data_r;

    ctrl_nxt  = ctrl_w;
    head_nxt  = head_r;
    count_nxt = count_q;
    if (present) begin
      ctrl_nxt.reply = 1'b1;
      in_msg_nxt     = pdata;
      head_nxt       = head_inc;
      count_nxt      = count_q - CNT_W'(1);
    end

    res.irq_request      = (ctrl_nxt.reply && ctrl_nxt.reply_ie)
                        || (ctrl_nxt.ack && ctrl_nxt.ack_ie);
    res.request_pending  = ctrl_nxt.req;
    res.outgoing_message = out_msg_nxt;
  end

  // queue memory: write the tail, prefetch the next head with forwarding
  always_ff @(posedge clk) begin
    if (enq) begin
      reply_mem[tail] <= in_data.reply_address;
    end
    if (enq && (tail == head_nxt)) begin
      head_data_r <= in_data.reply_address;
    end else begin
      head_data_r <= reply_mem[head_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_msg_r    <= '0;
      in_msg_r     <= '0;
      ctrl_r       <= '0;
      gpio_out_r   <= '0;
      gpio_dir_r   <= '0;
      reset_word_r <= '0;
      head_r       <= '0;
      count_r      <= '0;
    end else begin
      out_msg_r    <= out_msg_nxt;
      in_msg_r     <= in_msg_nxt;
      ctrl_r       <= ctrl_nxt;
      gpio_out_r   <= gpio_out_nxt;
      gpio_dir_r   <= gpio_dir_nxt;
      reset_word_r <= reset_word_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      priority if (!out_valid_r || !out_stall) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= acc;
        end
      end else if (acc) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (!out_valid_r || !out_stall) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (acc) begin
      skid_data_r <= res;
    end
  end

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sv/mbx_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbx_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input mbx_pkg::out_item_t out_data
);

  // hold a stalled result
  `MBX_ASSERT_NXT(a_out_hold, !rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // skid entry only fills behind a waiting result
  `MBX_ASSERT_IMP(a_stall_needs_out, !rst_n, in_stall, out_valid)

  // an accepted request always leaves a result on show
  `MBX_ASSERT_NXT(a_accept_gives_out, !rst_n, in_valid && !in_stall, out_valid)

  // reset drops any result and opens the input
  `MBX_ASSERT_NXT(a_reset_clears, 1'b0, !rst_n, !out_valid && !in_stall)

  // a dropped reply never comes from a bus access
  `MBX_ASSERT_IMP(a_status_excl, !rst_n, out_valid,
                  !(out_data.unknown_offset && out_data.reply_dropped))

endmodule

bind ipc_mailbox_with_reply_queue_top mbx_chk u_mbx_chk (.*);
